/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/v4alu_pkg.sv */
// ----------------------------------------------------------------------------
// v4alu_pkg
// Operation codes, defaults and saturation helpers of the vector ALU.
// ----------------------------------------------------------------------------
package v4alu_pkg;

  localparam int NumLanes    = 4;
  localparam int LanesDef    = 4;
  localparam int FracBitsDef = 16;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_LEN   = 3'd4;
  localparam logic [2:0] OP_NORM  = 3'd5;
  localparam logic [2:0] OP_SCALE = 3'd6;
  localparam logic [2:0] OP_DIV   = 3'd7;

  function automatic logic signed [67:0] sx68(input logic [31:0] v);
    return $signed({{36{v[31]}}, v});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [67:0] x);
    logic [31:0] res;
    if (x > 68'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (x < -68'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/vector4_alu.sv */
// ----------------------------------------------------------------------------
// vector4_alu
// Four-lane signed fixed-point vector ALU: add, sub, mul, dot, length,
// normalize, scale and divide, with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle unless the output side stalls, and raises
// m_axis_tvalid_o for each result in order. Every operation runs through
// the same 71-register pipeline: input register, multiplier, product sum, 32
// restoring square-root steps (one result bit each), length rounding, divider
// setup, 33 restoring divider steps per lane (one quotient bit each) and the
// output register. A stall on the output side freezes the whole pipeline, so
// s_axis_tready_o is low only while a result waits and m_axis_tready_i is low.
module vector4_alu #(
  parameter int LANES     = v4alu_pkg::LanesDef,
  parameter int FRAC_BITS = v4alu_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_0, a_1, a_2, a_3, b_0, b_1, b_2, b_3, scalar_in
  input  logic [287:0] s_axis_tdata_i,
  // req_type
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // r_0, r_1, r_2, r_3, scalar_out
  output logic [159:0] m_axis_tdata_o,
  // div_error
  output logic         m_axis_tuser_o
);

  localparam int NL       = v4alu_pkg::NumLanes;
  localparam int DW       = 66;
  localparam int ST_MUL   = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_SQ0   = 3;
  localparam int ST_LEN   = ST_SQ0 + 32;
  localparam int ST_DPREP = ST_LEN + 1;
  localparam int ST_DIV0  = ST_DPREP + 1;
  localparam int ST_OUT   = ST_DIV0 + 33;
  localparam int NSTAGE   = ST_OUT + 1;
  localparam logic signed [67:0] HalfQ = 68'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [2:0]             op;
    logic [NL-1:0][31:0]    a;
    logic [NL-1:0][31:0]    b;
    logic [31:0]            sc;
    logic [NL-1:0][63:0]    prod;
    logic [67:0]            acc;
    logic                   carry;
    logic [63:0]            rest;
    logic [63:0]            root;
    logic [32:0]            dv;
    logic [NL-1:0][DW-1:0]  rem;
    logic [NL-1:0][32:0]    q;
    logic [NL-1:0]          ovf;
    logic [NL-1:0]          neg;
    logic [NL-1:0][31:0]    r;
    logic [31:0]            so;
    logic                   err;
  } pipe_t;

  pipe_t st_d [NSTAGE];
  pipe_t st_q [NSTAGE];
  logic  vld_q [NSTAGE];
  logic  en;

  assign en              = !vld_q[NSTAGE-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    if (s == 0) begin : g_in
      always_comb begin
        st_d[s]    = '0;
        st_d[s].op = s_axis_tuser_i;
        st_d[s].sc = s_axis_tdata_i[256 +: 32];
        for (int i = 0; i < NL; i++) begin
          if (i < LANES) begin
            st_d[s].a[i] = s_axis_tdata_i[32*i +: 32];
            st_d[s].b[i] = s_axis_tdata_i[32*(i+NL) +: 32];
          end
        end
      end
    end else if (s == ST_MUL) begin : g_mul
      always_comb begin
        logic [31:0] x;
        st_d[s] = st_q[s-1];
        for (int i = 0; i < NL; i++) begin
          unique case (st_q[s-1].op)
            v4alu_pkg::OP_SCALE: x = st_q[s-1].sc;
            v4alu_pkg::OP_LEN,
            v4alu_pkg::OP_NORM:  x = st_q[s-1].a[i];
            default:             x = st_q[s-1].b[i];
          endcase
          st_d[s].prod[i] = $signed(st_q[s-1].a[i]) * $signed(x);
          if (st_q[s-1].op == v4alu_pkg::OP_ADD) begin
            st_d[s].r[i] = v4alu_pkg::sat32(v4alu_pkg::sx68(st_q[s-1].a[i]) +
                                            v4alu_pkg::sx68(st_q[s-1].b[i]));
          end else if (st_q[s-1].op == v4alu_pkg::OP_SUB) begin
            st_d[s].r[i] = v4alu_pkg::sat32(v4alu_pkg::sx68(st_q[s-1].a[i]) -
                                            v4alu_pkg::sx68(st_q[s-1].b[i]));
          end
        end
      end
    end else if (s == ST_SUM) begin : g_sum
      always_comb begin
        logic signed [67:0] dsum;
        logic signed [67:0] pr;
        logic        [65:0] ssum;
        st_d[s] = st_q[s-1];
        dsum    = '0;
        ssum    = '0;
        for (int i = 0; i < NL; i++) begin
          pr   = $signed({{4{st_q[s-1].prod[i][63]}}, st_q[s-1].prod[i]});
          dsum = dsum + pr;
          ssum = ssum + {2'b00, st_q[s-1].prod[i]};
          if (st_q[s-1].op == v4alu_pkg::OP_MUL || st_q[s-1].op == v4alu_pkg::OP_SCALE) begin
            st_d[s].r[i] = v4alu_pkg::sat32((pr + HalfQ) >>> FRAC_BITS);
          end
        end
        st_d[s].acc   = (st_q[s-1].op == v4alu_pkg::OP_DOT) ? dsum : {2'b00, ssum};
        st_d[s].carry = ssum[64];
        st_d[s].rest  = ssum[63:0];
        st_d[s].root  = '0;
      end
    end else if (s >= ST_SQ0 && s < ST_LEN) begin : g_sqrt
      localparam int K = s - ST_SQ0;
      always_comb begin
        logic [63:0] bitv;
        logic [63:0] t;
        st_d[s] = st_q[s-1];
        bitv    = 64'd1 << (62 - 2*K);
        t       = st_q[s-1].root + bitv;
        if (st_q[s-1].rest >= t) begin
          st_d[s].rest = st_q[s-1].rest - t;
          st_d[s].root = (st_q[s-1].root >> 1) + bitv;
        end else begin
          st_d[s].root = st_q[s-1].root >> 1;
        end
        // dot rounding rides along in the first root step
        if (K == 0 && st_q[s-1].op == v4alu_pkg::OP_DOT) begin
          st_d[s].so = v4alu_pkg::sat32(($signed(st_q[s-1].acc) + HalfQ) >>> FRAC_BITS);
        end
      end
    end else if (s == ST_LEN) begin : g_len
      always_comb begin
        logic [32:0] len;
        st_d[s] = st_q[s-1];
        if (st_q[s-1].carry) begin
          len = 33'h1_0000_0000;
        end else begin
          len = st_q[s-1].root[32:0] +
                {32'd0, (st_q[s-1].rest > st_q[s-1].root)};
        end
        st_d[s].dv = len;
        if (st_q[s-1].op == v4alu_pkg::OP_LEN) begin
          st_d[s].so = v4alu_pkg::sat32($signed({35'd0, len}));
        end
      end
    end else if (s == ST_DPREP) begin : g_dprep
      always_comb begin
        logic [32:0] d;
        logic [32:0] av;
        logic [32:0] amag;
        logic [32:0] sv;
        logic [DW-1:0] num;
        logic        dneg;
        st_d[s] = st_q[s-1];
        sv      = {st_q[s-1].sc[31], st_q[s-1].sc};
        dneg    = (st_q[s-1].op == v4alu_pkg::OP_DIV) && st_q[s-1].sc[31];
        if (st_q[s-1].op == v4alu_pkg::OP_NORM) begin
          d = st_q[s-1].dv;
        end else begin
          d = sv[32] ? (~sv + 33'd1) : sv;
        end
        st_d[s].dv  = d;
        st_d[s].err = (st_q[s-1].op == v4alu_pkg::OP_NORM ||
                       st_q[s-1].op == v4alu_pkg::OP_DIV) && (d == '0);
        for (int i = 0; i < NL; i++) begin
          av   = {st_q[s-1].a[i][31], st_q[s-1].a[i]};
          amag = av[32] ? (~av + 33'd1) : av;
          num  = ({33'd0, amag} << FRAC_BITS) + {34'd0, d[32:1]};
          st_d[s].rem[i] = num;
          st_d[s].ovf[i] = num >= {d, 33'd0};
          st_d[s].neg[i] = st_q[s-1].a[i][31] ^ dneg;
          st_d[s].q[i]   = '0;
        end
      end
    end else if (s >= ST_DIV0 && s < ST_OUT) begin : g_div
      localparam int K = 32 - (s - ST_DIV0);
      always_comb begin
        logic [DW-1:0] dsh;
        st_d[s] = st_q[s-1];
        dsh     = {33'd0, st_q[s-1].dv} << K;
        for (int i = 0; i < NL; i++) begin
          if (st_q[s-1].rem[i] >= dsh) begin
            st_d[s].rem[i]  = st_q[s-1].rem[i] - dsh;
            st_d[s].q[i][K] = 1'b1;
          end
        end
      end
    end else begin : g_out
      always_comb begin
        logic [32:0] sm;
        logic [32:0] ng;
        st_d[s] = st_q[s-1];
        for (int i = 0; i < NL; i++) begin
          sm = (st_q[s-1].ovf[i] || st_q[s-1].q[i] > 33'h0_8000_0000) ?
               33'h0_8000_0000 : st_q[s-1].q[i];
          ng = ~sm + 33'd1;
          if (st_q[s-1].op == v4alu_pkg::OP_NORM || st_q[s-1].op == v4alu_pkg::OP_DIV) begin
            if (st_q[s-1].neg[i]) begin
              st_d[s].r[i] = ng[31:0];
            end else begin
              st_d[s].r[i] = sm[31] ? 32'h7FFF_FFFF : sm[31:0];
            end
          end
          if (st_q[s-1].err || i >= LANES) begin
            st_d[s].r[i] = '0;
          end
        end
        if (st_q[s-1].err) begin
          st_d[s].so = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTAGE; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int s = 1; s < NSTAGE; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NSTAGE; s++) st_q[s] <= st_d[s];
    end
  end

  assign m_axis_tvalid_o = vld_q[NSTAGE-1];
  assign m_axis_tdata_o  = {st_q[NSTAGE-1].so, st_q[NSTAGE-1].r[3], st_q[NSTAGE-1].r[2],
                            st_q[NSTAGE-1].r[1], st_q[NSTAGE-1].r[0]};
  assign m_axis_tuser_o  = st_q[NSTAGE-1].err;

`include "assert_macros.svh"

  `ASSERT_PROP(a_err_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0, "error result carries data")
  `ASSERT_PROP(a_err_op, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> st_q[NSTAGE-1].op == v4alu_pkg::OP_NORM || st_q[NSTAGE-1].op == v4alu_pkg::OP_DIV, "error flag on non-divide op")
  `ASSERT_PROP(a_so_op, clk_i, rst_ni, m_axis_tvalid_o && st_q[NSTAGE-1].op != v4alu_pkg::OP_DOT && st_q[NSTAGE-1].op != v4alu_pkg::OP_LEN |-> m_axis_tdata_o[159:128] == '0, "scalar result on vector op")
  `ASSERT_PROP(a_stall_hold, clk_i, rst_ni, !en |=> $stable(vld_q[ST_LEN]) && $stable(vld_q[ST_DPREP]), "pipeline moved during stall")

endmodule
